// File: hw/rtl/d6tlv_pkg.sv
// shared types, constants and functions for the dhcpv6 option scanner
// no dependencies; imported by d6tlv_scan, d6tlv_outq and the top level
package d6tlv_pkg;

    // message header length in bytes, skipped before the option chain
    localparam int unsigned HEADER_BYTES = 4;
    // option header: 16-bit code and 16-bit length
    localparam int unsigned OPT_HDR_LEN  = 4;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned POS_W        = 16;
    localparam int unsigned NEXT_W       = POS_W + 1;
    localparam int unsigned SLOT_W       = 3;
    localparam int unsigned NUM_SLOTS    = 5;
    localparam int unsigned OUTQ_DEPTH   = 4;

    // tracked option codes
    localparam logic [15:0] OPT_CLIENT_ID   = 16'd1;
    localparam logic [15:0] OPT_SERVER_ID   = 16'd2;
    localparam logic [15:0] OPT_DNS_SERVERS = 16'd23;
    localparam logic [15:0] OPT_DOMAIN_LIST = 16'd24;
    localparam logic [15:0] OPT_SNTP        = 16'd31;

    // slot numbers
    localparam logic [SLOT_W-1:0] SLOT_CLIENT_ID   = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_SERVER_ID   = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_DNS_SERVERS = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_DOMAIN_LIST = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_SNTP        = 3'd4;

    // record kinds
    localparam logic KIND_OPTION = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic                  record_kind;
        logic [SLOT_W-1:0]     option_slot;
        logic [POS_W-1:0]      value_offset;
        logic [15:0]           value_length;
        logic [NUM_SLOTS-1:0]  slots_seen;
        logic                  end_of_run;
    } t_result;

    // up to two records per request, r0 goes out first
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_slot_hit;

    function automatic t_slot_hit code_to_slot(input logic [15:0] code);
        t_slot_hit res;
        res.hit  = 1'b1;
        res.slot = SLOT_CLIENT_ID;
        case (code)
            OPT_CLIENT_ID:   res.slot = SLOT_CLIENT_ID;
            OPT_SERVER_ID:   res.slot = SLOT_SERVER_ID;
            OPT_DNS_SERVERS: res.slot = SLOT_DNS_SERVERS;
            OPT_DOMAIN_LIST: res.slot = SLOT_DOMAIN_LIST;
            OPT_SNTP:        res.slot = SLOT_SNTP;
            default:         res.hit  = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: hw/rtl/dhcpv6_option_tlv_parser.sv
// top level of the dhcpv6 reply option scanner
// depends on d6tlv_pkg, d6tlv_scan and d6tlv_outq
//
// Takes a DHCPv6 reply one byte per request and reports where the client id,
// server id, DNS servers, domain list and SNTP servers options sit. The first
// four bytes (message header) are skipped; each option header (16-bit code,
// 16-bit length, big-endian) that completes with a tracked code yields an
// option record with slot, value offset and value length as given. The byte
// flagged last yields an end record with the mask of slots seen, and the
// scanner returns to its reset state for the next message. Throughput is one
// byte per cycle: each byte is folded into the scanner state by one compare
// and one 17-bit add at acceptance, and its records land in a four-entry
// result queue that is read one record per cycle. Records are written into the
// queue when their byte is accepted and leave it from its head in order. Only a
// byte that both completes a tracked option header and is flagged last gives two
// records; the queue hands those out in turn, and since the bytes that follow
// cannot give two records again before the queue has emptied, the input
// never has to pause while the output side takes one record per cycle.
module dhcpv6_option_tlv_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // record output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_record_kind,
    output logic [2:0]  o_option_slot,
    output logic [15:0] o_value_offset,
    output logic [15:0] o_value_length,
    output logic [4:0]  o_slots_seen,
    output logic        o_end_of_run
);
    import d6tlv_pkg::*;

    logic    accept;
    logic    room;
    t_push   push;
    t_result head;

    // a request is taken only while the queue can absorb two records
    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    d6tlv_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push)
    );

    d6tlv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    // record fields straight from the queue head
    assign o_record_kind  = head.record_kind;
    assign o_option_slot  = head.option_slot;
    assign o_value_offset = head.value_offset;
    assign o_value_length = head.value_length;
    assign o_slots_seen   = head.slots_seen;
    assign o_end_of_run   = head.end_of_run;

    // end records carry no slot, offset or length
    a_end_rec_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_kind == KIND_END)
            |-> (o_option_slot == '0 && o_value_offset == '0 && o_value_length == '0
                 && o_end_of_run))
        else $error("malformed end record");

    // option records carry a valid slot and no mask
    a_opt_rec_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_record_kind == KIND_OPTION)
            |-> (o_option_slot <= SLOT_SNTP && o_slots_seen == '0))
        else $error("malformed option record");

    // an accepted request that gives two records makes the output valid in the next cycle
    a_ready_means_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && push.count == 2'd2) |=> o_out_valid)
        else $error("double record lost");

endmodule

// File: hw/rtl/d6tlv_scan.sv
// option chain walker: position tracking, option header capture, record build
// depends on d6tlv_pkg
module d6tlv_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [d6tlv_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic                           i_last_byte,
    output d6tlv_pkg::t_push               o_push
);
    import d6tlv_pkg::*;

    logic [POS_W-1:0]     r_byte_pos,  n_byte_pos;
    logic [NEXT_W-1:0]    r_next_opt,  n_next_opt;
    logic [23:0]          r_hdr,       n_hdr;
    logic [1:0]           r_hdr_count, n_hdr_count;
    logic                 r_in_header, n_in_header;
    logic [NUM_SLOTS-1:0] r_seen,      n_seen;

    logic [15:0]       code;
    logic [15:0]       len;
    logic [NEXT_W-1:0] val_off;
    t_slot_hit         sh;
    logic              opt_hit;
    t_result           opt_rec;
    t_result           end_rec;

    always_comb begin
        code    = r_hdr[23:8];
        len     = {r_hdr[7:0], i_data_byte};
        val_off = {1'b0, r_byte_pos} + NEXT_W'(1);
        sh      = code_to_slot(code);
        opt_hit = 1'b0;

        n_byte_pos  = r_byte_pos + POS_W'(1);
        n_next_opt  = r_next_opt;
        n_hdr       = r_hdr;
        n_hdr_count = r_hdr_count;
        n_in_header = r_in_header;
        n_seen      = r_seen;

        if (r_in_header) begin
            if (r_hdr_count < 2'(OPT_HDR_LEN - 1)) begin
                n_hdr       = {r_hdr[15:0], i_data_byte};
                n_hdr_count = r_hdr_count + 2'd1;
            end else begin
                n_next_opt  = val_off + {1'b0, len};
                n_in_header = 1'b0;
                n_hdr_count = 2'd0;
                n_hdr       = '0;
                if (sh.hit) begin
                    opt_hit = 1'b1;
                    n_seen  = r_seen | (NUM_SLOTS'(1) << sh.slot);
                end
            end
        end else if ({1'b0, r_byte_pos} == r_next_opt) begin
            n_in_header = 1'b1;
            n_hdr       = {16'd0, i_data_byte};
            n_hdr_count = 2'd1;
        end

        opt_rec.record_kind  = KIND_OPTION;
        opt_rec.option_slot  = sh.slot;
        opt_rec.value_offset = val_off[POS_W-1:0];
        opt_rec.value_length = len;
        opt_rec.slots_seen   = '0;
        opt_rec.end_of_run   = !i_last_byte;

        end_rec.record_kind  = KIND_END;
        end_rec.option_slot  = '0;
        end_rec.value_offset = '0;
        end_rec.value_length = '0;
        end_rec.slots_seen   = n_seen;
        end_rec.end_of_run   = 1'b1;

        // end of message clears everything
        if (i_last_byte) begin
            n_byte_pos  = '0;
            n_next_opt  = NEXT_W'(HEADER_BYTES);
            n_hdr       = '0;
            n_hdr_count = 2'd0;
            n_in_header = 1'b0;
            n_seen      = '0;
        end

        o_push.r0    = opt_hit ? opt_rec : end_rec;
        o_push.r1    = end_rec;
        o_push.count = i_accept ? ({1'b0, opt_hit} + {1'b0, i_last_byte}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos  <= '0;
            r_next_opt  <= NEXT_W'(HEADER_BYTES);
            r_hdr       <= '0;
            r_hdr_count <= 2'd0;
            r_in_header <= 1'b0;
            r_seen      <= '0;
        end else if (i_accept) begin
            r_byte_pos  <= n_byte_pos;
            r_next_opt  <= n_next_opt;
            r_hdr       <= n_hdr;
            r_hdr_count <= n_hdr_count;
            r_in_header <= n_in_header;
            r_seen      <= n_seen;
        end
    end

    // last byte returns the walker to its reset state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_byte_pos == '0 && r_seen == '0 && !r_in_header))
        else $error("state not cleared after last byte");

    // an option record only comes from a completed header
    a_rec_ends_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd0 && o_push.r0.record_kind == KIND_OPTION)
            |-> (r_in_header && r_hdr_count == 2'(OPT_HDR_LEN - 1)))
        else $error("option record without full header");

    // header count is nonzero exactly while a header is being read
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_header == (r_hdr_count != 2'd0))
        else $error("header count out of step");

endmodule

// File: hw/rtl/d6tlv_outq.sv
// four-entry result queue taking up to two records per cycle
// depends on d6tlv_pkg
module d6tlv_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  d6tlv_pkg::t_push     i_push,
    input  logic                 i_pop,
    output logic                 o_room,
    output logic                 o_valid,
    output d6tlv_pkg::t_result   o_head
);
    import d6tlv_pkg::*;

    localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    t_result            r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               pop_ok;

    always_comb begin
        pop_ok  = i_pop && (r_count != '0);
        n_wp    = r_wp + PTR_W'(i_push.count);
        n_rp    = r_rp + PTR_W'(pop_ok);
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop_ok);
    end

    assign o_room  = (r_count <= CNT_W'(OUTQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count == $past(r_count) + CNT_W'($past(i_push.count))
                             - CNT_W'($past(pop_ok))))
        else $error("queue count mismatch");

endmodule
